// ===== hdl/afs_pkg.sv =====
// ----------------------------------------------------------------------------
// afs_pkg
// Shared types and frame codes for the converter frame sequencer.
// ----------------------------------------------------------------------------
package afs_pkg;

	localparam int CHAN_W        = 3;
	localparam int CHAN_SLOTS    = 8;
	localparam int SAMPLE_W      = 16;
	localparam int WORD_W        = 16;
	localparam int ADDR_W        = 7;
	localparam int BYTE_W        = 8;

	typedef logic [CHAN_W-1:0]   chan_t;
	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [WORD_W-1:0]   word_t;
	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [BYTE_W-1:0]   byte_t;

	localparam word_t CMD_AUTO_RST  = 16'hA000;
	localparam word_t CMD_MAN_BASE  = 16'hC000;
	localparam word_t CMD_MAN_MASK  = 16'hE3FF;
	localparam addr_t ADDR_AUTO_SEQ = 7'h01;
	localparam addr_t ADDR_RANGE_BASE = 7'h05;
	localparam sample_t SIGN_FLIP   = 16'h8000;
	localparam byte_t MASK_RESET    = 8'hFF;
	localparam byte_t RANGE_CODE_MAX = 8'h06;
	localparam byte_t RANGE_RSVD_A  = 8'h03;
	localparam byte_t RANGE_RSVD_B  = 8'h04;

	typedef struct packed {
		chan_t lowest;
		chan_t next;
	} chan_pick_t;

endpackage

// ===== hdl/adc_spi_frame_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// adc_spi_frame_sequencer_top
// Frame-level sequencer of an eight-channel converter with manual and
// automatic channel selection.
// ----------------------------------------------------------------------------
// usage
//   input channel: one frame per transfer (in_valid / in_stall), a command
//   word or a program write plus the eight channel samples seen at that time
//   output channel: one result per frame (out_valid / out_stall); a command
//   frame returns the previous conversion and its channel, a program frame
//   returns the echoed data byte of a taken write, else zero
//   path: the frame goes from the input register through decode and
//   channel pick into the result register, where out_valid rises; a
//   receiver stall can hold it in the input register
//   throughput: one frame per cycle without receiver stall; the channel
//   pick is one combinational priority stage feeding the state registers
//   reset: manual mode on channel 0, held conversion 0, all mask bits set,
//   range codes 0, both stages empty
//   receiver stall: the result register holds, the input register fills,
//   and in_stall rises only when both are occupied
// ----------------------------------------------------------------------------
module adc_spi_frame_sequencer_top #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  logic [15:0]           frame_word,
	input  logic [15:0]           sample_ch0,
	input  logic [15:0]           sample_ch1,
	input  logic [15:0]           sample_ch2,
	input  logic [15:0]           sample_ch3,
	input  logic [15:0]           sample_ch4,
	input  logic [15:0]           sample_ch5,
	input  logic [15:0]           sample_ch6,
	input  logic [15:0]           sample_ch7,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [15:0]           read_data,
	output logic signed [15:0]    signed_sample,
	output logic [2:0]            data_channel,
	output logic [7:0]            echo_byte
);

	// input register
	logic                  valid_s1;
	logic                  req_type_s1;
	afs_pkg::word_t        word_s1;
	afs_pkg::sample_t      sample_s1 [afs_pkg::CHAN_SLOTS];

	// sequencer state
	afs_pkg::byte_t        auto_mask_q;
	afs_pkg::byte_t        range_codes_q [afs_pkg::CHAN_SLOTS];
	logic                  auto_mode_q;
	afs_pkg::chan_t        cur_chan_q;
	afs_pkg::sample_t      held_conv_q;
	afs_pkg::chan_t        held_chan_q;

	// result register
	logic                  out_valid_q;
	afs_pkg::sample_t      read_data_q;
	afs_pkg::chan_t        data_chan_q;
	afs_pkg::byte_t        echo_q;

	logic                  in_xfer;
	logic                  advance;
	afs_pkg::chan_pick_t   pick;

	// frame decode
	afs_pkg::addr_t        addr;
	logic                  wr_bit;
	afs_pkg::byte_t        data_byte;
	logic                  mask_wr;
	logic                  range_wr;
	logic                  code_ok;
	afs_pkg::chan_t        range_idx;
	logic                  is_auto_rst;
	logic                  is_manual;
	afs_pkg::chan_t        man_chan;
	logic                  cmd_frame;
	afs_pkg::chan_t        new_chan;
	logic                  new_mode;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_type_s1  <= req_type;
			word_s1      <= frame_word;
			sample_s1[0] <= sample_ch0;
			sample_s1[1] <= sample_ch1;
			sample_s1[2] <= sample_ch2;
			sample_s1[3] <= sample_ch3;
			sample_s1[4] <= sample_ch4;
			sample_s1[5] <= sample_ch5;
			sample_s1[6] <= sample_ch6;
			sample_s1[7] <= sample_ch7;
		end
	end

	afs_chan_pick #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_pick (
		.mask (auto_mask_q),
		.cur  (cur_chan_q),
		.pick (pick)
	);

	always_comb begin
		addr      = word_s1[15:9];
		wr_bit    = word_s1[8];
		data_byte = word_s1[7:0];
		code_ok   = (data_byte <= afs_pkg::RANGE_CODE_MAX)
			&& (data_byte != afs_pkg::RANGE_RSVD_A)
			&& (data_byte != afs_pkg::RANGE_RSVD_B);
		mask_wr   = req_type_s1 && wr_bit && (addr == afs_pkg::ADDR_AUTO_SEQ);
		range_wr  = req_type_s1 && wr_bit && code_ok
			&& (addr >= afs_pkg::ADDR_RANGE_BASE)
			&& (addr < afs_pkg::ADDR_W'(afs_pkg::ADDR_RANGE_BASE + NUM_CHANNELS));
		range_idx = afs_pkg::CHAN_W'(addr - afs_pkg::ADDR_RANGE_BASE);

		cmd_frame   = !req_type_s1;
		is_auto_rst = (word_s1 == afs_pkg::CMD_AUTO_RST);
		man_chan    = word_s1[12:10];
		is_manual   = ((word_s1 & afs_pkg::CMD_MAN_MASK) == afs_pkg::CMD_MAN_BASE)
			&& ({1'b0, man_chan} < 4'(NUM_CHANNELS));

		new_mode = auto_mode_q;
		new_chan = cur_chan_q;
		if (is_auto_rst) begin
			new_mode = 1'b1;
			new_chan = pick.lowest;
		end else if (is_manual) begin
			new_mode = 1'b0;
			new_chan = man_chan;
		end else if (auto_mode_q) begin
			new_chan = pick.next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_mask_q <= afs_pkg::MASK_RESET;
			auto_mode_q <= 1'b0;
			cur_chan_q  <= '0;
			held_conv_q <= '0;
			held_chan_q <= '0;
			for (int i = 0; i < afs_pkg::CHAN_SLOTS; i++) begin
				range_codes_q[i] <= '0;
			end
		end else if (advance) begin
			if (mask_wr) begin
				auto_mask_q <= data_byte;
			end
			if (range_wr) begin
				range_codes_q[range_idx] <= data_byte;
			end
			if (cmd_frame) begin
				auto_mode_q <= new_mode;
				cur_chan_q  <= new_chan;
				held_chan_q <= new_chan;
				held_conv_q <= sample_s1[new_chan];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= cmd_frame ? held_conv_q : '0;
			data_chan_q <= cmd_frame ? held_chan_q : '0;
			echo_q      <= (mask_wr || range_wr) ? data_byte : '0;
		end
	end

	// sign flip is kept out of the result register, it only applies to command frames
	logic result_is_cmd_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			result_is_cmd_q <= cmd_frame;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_data     = read_data_q;
	assign signed_sample = result_is_cmd_q ? signed'(read_data_q ^ afs_pkg::SIGN_FLIP) : '0;
	assign data_channel  = data_chan_q;
	assign echo_byte     = echo_q;

endmodule

// ===== hdl/afs_chan_pick.sv =====
// ----------------------------------------------------------------------------
// afs_chan_pick
// Priority pick of the lowest enabled channel and of the next enabled
// channel above the current one, with wrap.
// ----------------------------------------------------------------------------
module afs_chan_pick #(
	parameter int NUM_CHANNELS = 8
) (
	input  afs_pkg::byte_t     mask,
	input  afs_pkg::chan_t     cur,
	output afs_pkg::chan_pick_t pick
);

	localparam int SUM_W = afs_pkg::CHAN_W + 1;

	always_comb begin
		logic [SUM_W-1:0] sum;
		pick.lowest = '0;
		pick.next   = cur;
		for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
			if (mask[c]) begin
				pick.lowest = afs_pkg::chan_t'(c);
			end
		end
		// walk from the furthest step back so the nearest enabled channel wins
		for (int i = NUM_CHANNELS; i >= 1; i--) begin
			sum = {1'b0, cur} + SUM_W'(i);
			if (sum >= SUM_W'(NUM_CHANNELS)) begin
				sum = sum - SUM_W'(NUM_CHANNELS);
			end
			if (mask[sum[afs_pkg::CHAN_W-1:0]]) begin
				pick.next = sum[afs_pkg::CHAN_W-1:0];
			end
		end
	end

endmodule
